// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median filter
// Widths, the signed-to-unsigned key bias and the cell data structures.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 7;
    localparam int AGE_W      = 6;
    localparam int IDX_W      = 6;

    // Flipping the sign bit turns signed order into unsigned order.
    localparam logic [DATA_W-1:0] SIGN_BIAS = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [AGE_W-1:0]  age;
    } cell_t;

    // Broadcast to every cell for the word being taken in.
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [AGE_W-1:0]  len_m1;
        logic              full;
        logic              load;
    } cell_ctrl_t;

endpackage

// ===== src/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample key and its age; removes the oldest sample and inserts
// the new one together, trading entries with its neighbours.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic               aclk,
    input  swm_pkg::cell_ctrl_t ctrl_i,
    input  logic               valid_i,
    input  logic               rem_valid_i,
    input  logic               left_g_i,
    input  swm_pkg::cell_t     left_rem_i,
    input  swm_pkg::cell_t     right_i,
    input  logic               dl_i,
    output swm_pkg::cell_t     stored_o,
    output swm_pkg::cell_t     rem_o,
    output logic               g_o,
    output logic               dl_o
);
    import swm_pkg::*;

    cell_t data_reg;
    cell_t data_next;
    logic  del_self;

    // The evicted sample is the one whose age has reached the window length minus one.
    assign del_self = ctrl_i.full && valid_i && (data_reg.age == ctrl_i.len_m1);
    assign dl_o     = dl_i || del_self;
    // Once the eviction point lies at or before this slot, the entry closes up.
    assign rem_o    = dl_o ? right_i : data_reg;
    assign g_o      = !rem_valid_i || (rem_o.key > ctrl_i.key);

    always_comb begin
        if (left_g_i) begin
            data_next.key = left_rem_i.key;
            data_next.age = left_rem_i.age + 1'b1;
        end else if (g_o) begin
            data_next.key = ctrl_i.key;
            data_next.age = '0;
        end else begin
            data_next.key = rem_o.key;
            data_next.age = rem_o.age + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.load) begin
            data_reg <= data_next;
        end
    end

    assign stored_o = data_reg;

endmodule

// ===== src/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median: running lower median over a sliding window
// A row of sorted cells keeps the window ordered; each cell also tracks the
// age of its sample so the oldest one can be dropped as a new one arrives.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per sample; s_tdata is the signed sample, s_tuser
//   is the start flag, which empties the window before the sample is taken.
//   m_ channel: m_tdata is the lower median, sent once the window is full.
//   cfg channel: writes the window length (1 to 64; 0 acts as 1, larger
//   values as 64) and empties the window. Write only while idle.
// Throughput: one sample per cycle while s_tready is high. The whole cell
//   row removes the oldest sample and inserts the new one on acceptance.
// Path: an accepted word updates the cells; when the output is free the
//   median is read from the cells into the output register behind m_tvalid.
// Stall: a result waits in the output register; one more result may wait
//   in the cells, after which s_tready drops until m_tready returns.
// Reset: the window is empty, the length is one, and no result is pending.
// ----------------------------------------------------------------------------
module sliding_window_median (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swm_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                        s_tuser,   // [0] start_req
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swm_pkg::DATA_W-1:0]  m_tdata,   // [31:0] median
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [swm_pkg::LEN_W-1:0]   cfg_data
);
    import swm_pkg::*;

    logic [LEN_W-1:0]  window_len_reg;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic              pend_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic [LEN_W-1:0]  eff_len;
    logic [AGE_W-1:0]  len_m1;
    logic [LEN_W-1:0]  cur_fill;
    logic [LEN_W-1:0]  rem_fill;
    logic              full;
    logic              take;
    logic              emit;
    logic              out_free;
    cell_ctrl_t        ctrl;

    cell_t             stored  [WINDOW_MAX];
    cell_t             rem     [WINDOW_MAX];
    logic              g       [WINDOW_MAX];
    logic              dl      [WINDOW_MAX];
    logic [IDX_W-1:0]  mid_idx;

    always_comb begin
        if (window_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (window_len_reg > LEN_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = window_len_reg;
        end
    end

    assign len_m1   = AGE_W'(eff_len - 1'b1);
    assign mid_idx  = IDX_W'(len_m1 >> 1);
    assign cur_fill = s_tuser ? '0 : fill_reg;
    assign full     = (cur_fill == eff_len);
    assign rem_fill = full ? cur_fill - 1'b1 : cur_fill;
    assign fill_next = full ? cur_fill : cur_fill + 1'b1;
    assign emit     = (fill_next == eff_len);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign take     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ctrl.key    = s_tdata ^ SIGN_BIAS;
    assign ctrl.len_m1 = len_m1;
    assign ctrl.full   = full;
    assign ctrl.load   = take;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell u_cell (
            .aclk        (aclk),
            .ctrl_i      (ctrl),
            .valid_i     (LEN_W'(i) < cur_fill),
            .rem_valid_i (LEN_W'(i) < rem_fill),
            .left_g_i    ((i == 0) ? 1'b0 : g[(i == 0) ? 0 : i-1]),
            .left_rem_i  (rem[(i == 0) ? 0 : i-1]),
            .right_i     ((i == WINDOW_MAX-1) ? cell_t'('0)
                                              : stored[(i == WINDOW_MAX-1) ? i : i+1]),
            .dl_i        ((i == 0) ? 1'b0 : dl[(i == 0) ? 0 : i-1]),
            .stored_o    (stored[i]),
            .rem_o       (rem[i]),
            .g_o         (g[i]),
            .dl_o        (dl[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= LEN_W'(1);
            fill_reg       <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_len_reg <= cfg_data;
                fill_reg       <= '0;
            end else if (take) begin
                fill_reg <= fill_next;
            end
            // A pending median leaves the cells before they can change again.
            if (pend_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (take) begin
                pend_reg <= emit;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg && out_free) begin
            out_data_reg <= stored[mid_idx].key ^ SIGN_BIAS;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sliding window median filter
// A queue of sample words feeds a clocked driver; a clocked monitor compares
// each median word with a running-median model kept in the bench. Phases
// cover several window lengths, random idling on both sides and one long
// receiver hold-off that backs the filter up.
// ----------------------------------------------------------------------------
module testbench;
    import swm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] sample;
    } sample_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     cfg_data  = '0;

    sample_word_t             sample_q[$];
    logic signed [DATA_W-1:0] median_q[$];

    // Model of the window: ring in arrival order plus an ascending copy.
    logic signed [DATA_W-1:0] win_ring   [WINDOW_MAX];
    logic signed [DATA_W-1:0] win_sorted [WINDOW_MAX];
    int unsigned              win_fill   = 0;
    int unsigned              win_oldest = 0;
    logic [LEN_W-1:0]         win_len_reg = 7'd1;

    int  tx_idle_max = 0;
    int  rx_idle_max = 0;
    int  tx_gap      = 0;
    int  rx_wait     = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  hold_go     = 1'b0;
    logic rx_hold    = 1'b0;

    sliding_window_median i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Takes one sample into the model window and gives the lower median
    // once the window is full.
    task automatic advance_window(input logic signed [DATA_W-1:0] smp,
                                  input logic start,
                                  output bit got,
                                  output logic signed [DATA_W-1:0] med);
        int unsigned len;
        int unsigned slot;
        int unsigned i;
        logic signed [DATA_W-1:0] evicted;
        len = win_len_reg;
        if (len == 0) len = 1;
        if (len > WINDOW_MAX) len = WINDOW_MAX;
        if (start) begin
            win_fill   = 0;
            win_oldest = 0;
        end
        if (win_fill == len) begin
            slot    = win_oldest;
            evicted = win_ring[slot];
            // Only one copy of a repeated value leaves the window.
            i = 0;
            while (i < win_fill && win_sorted[i] != evicted) i++;
            while (i + 1 < win_fill) begin
                win_sorted[i] = win_sorted[i + 1];
                i++;
            end
            win_ring[slot] = smp;
            win_oldest     = (slot + 1) % len;
            i              = win_fill - 1;
        end else begin
            slot           = (win_oldest + win_fill) % len;
            win_ring[slot] = smp;
            i              = win_fill;
            win_fill++;
        end
        while (i > 0 && win_sorted[i - 1] > smp) begin
            win_sorted[i] = win_sorted[i - 1];
            i--;
        end
        win_sorted[i] = smp;
        got = (win_fill == len);
        med = win_sorted[(len - 1) / 2];
    endtask

    // Sender: a word leaves the bus when taken, and the next one follows
    // after its own drawn gap.
    always @(posedge aclk) begin : word_driver
        bit got;
        logic signed [DATA_W-1:0] med;
        sample_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_window(s_tdata, s_tuser, got, med);
                if (got) median_q = {median_q, med};
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    w        = sample_q.pop_front();
                    s_tdata  <= w.sample;
                    s_tuser  <= w.start;
                    s_tvalid <= 1'b1;
                    tx_gap   <= $urandom_range(0, tx_idle_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each median word and draws a stall before the next.
    always @(posedge aclk) begin : median_monitor
        int wait_n;
        logic signed [DATA_W-1:0] want;
        wait_n = rx_wait;
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("median %0d arrived with none expected",
                                          $signed(m_tdata)));
            end else begin
                want = median_q.pop_front();
                if ($signed(m_tdata) !== want)
                    report_mismatch($sformatf("median %0d, expected %0d",
                                              $signed(m_tdata), want));
            end
            wait_n = $urandom_range(0, rx_idle_max);
        end else if (wait_n > 0) begin
            wait_n--;
        end
        rx_wait  <= wait_n;
        m_tready <= aresetn && (wait_n == 0) && !rx_hold;
    end

    // Long receiver hold-off while the sender keeps offering words.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_word(input logic signed [DATA_W-1:0] smp, input logic start);
        sample_word_t w;
        w.sample = smp;
        w.start  = start;
        sample_q = {sample_q, w};
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || median_q.size() != 0);
        // A last word that yields no median may still be inside the filter.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_len(input logic [LEN_W-1:0] len);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        win_len_reg = len;
        win_fill    = 0;
        win_oldest  = 0;
    endtask

    task automatic random_phase(input logic [LEN_W-1:0] len, input int count,
                                input int start_pct, input int tx_max, input int rx_max);
        write_window_len(len);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        for (int n = 0; n < count; n++)
            push_word(rand_sample(), $urandom_range(0, 99) < start_pct);
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Window of one after reset: every word passes straight through.
        push_word(INT_MIN, 1'b0);
        push_word(INT_MAX, 1'b0);
        push_word(0, 1'b0);
        push_word(-1, 1'b1);
        push_word(1, 1'b0);
        wait_idle();

        // Window of three with extremes, repeats and a restart mid-stream.
        write_window_len(7'd3);
        push_word(INT_MAX, 1'b0);
        push_word(INT_MIN, 1'b0);
        push_word(INT_MAX, 1'b0);
        push_word(INT_MAX, 1'b0);
        push_word(INT_MIN, 1'b0);
        push_word(INT_MIN, 1'b0);
        push_word(7, 1'b1);
        push_word(7, 1'b0);
        push_word(7, 1'b0);
        push_word(-7, 1'b0);
        wait_idle();

        // A zero length behaves as a window of one.
        write_window_len(7'd0);
        push_word(-5, 1'b0);
        push_word(5, 1'b1);
        wait_idle();

        // Even window: the lower of the two middle words.
        write_window_len(7'd2);
        push_word(3, 1'b0);
        push_word(-3, 1'b0);
        push_word(10, 1'b1);
        push_word(-10, 1'b0);
        wait_idle();

        random_phase(7'd64, 120, 0, 16, 16);
        random_phase(7'd1, 60, 10, 0, 0);

        // Length above the maximum saturates; the receiver stops meanwhile.
        hold_go = 1'b1;
        random_phase(7'd127, 90, 0, 0, 0);

        for (int p = 0; p < 4; p++)
            random_phase(LEN_W'($urandom_range(2, 8)), 40, 15, $urandom_range(0, 16),
                         $urandom_range(0, 16));
        random_phase(7'd33, 80, 1, 4, 16);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median.sv
tb/testbench.sv
